// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions, disabled while the active-low reset is asserted
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define FRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication outside reset
`define FRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `FRC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: rtl/core/frc_pkg.sv
// ---------------------------------------------------------------------------
// frc_pkg
// shared types and constants of the fragment reassembly checker
// ---------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SRC_W      = 48;
  localparam int unsigned WL_W       = 11;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DIV_STEPS  = 7;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned DIVIDEND_W = WORD_W + DIV_STEPS;

  localparam logic [PCT_W-1:0] PCT_NONE = 7'd127;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic REG_TYPE_CODE = 1'b0;

  typedef enum logic [1:0] {
    CMD_INFO  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_SHORT      = 3'd1,
    STAT_WRONG_TYPE = 3'd2,
    STAT_FOREIGN    = 3'd3,
    STAT_IDLE_EMPTY = 3'd4,
    STAT_BAD_INFO   = 3'd5,
    STAT_ORDER      = 3'd6,
    STAT_UNKNOWN    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] numer;
    logic [WORD_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/frc_pctdiv.sv
// ---------------------------------------------------------------------------
// frc_pctdiv
// percent divider: floor(numer * 100 / denom), one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module frc_pctdiv
  import frc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  run_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] rem_r;
  logic [DIVIDEND_W-1:0] dsh_r;
  logic [PCT_W-1:0]      q_r;

  logic [DIVIDEND_W-1:0] numer_ext;
  logic [DIVIDEND_W-1:0] prod;
  logic                  ge;
  logic [DIVIDEND_W-1:0] diff;

  // times 100 as 64 + 32 + 4
  assign numer_ext = {{DIV_STEPS{1'b0}}, req.numer};
  assign prod      = (numer_ext << 6) + (numer_ext << 5) + (numer_ext << 2);
  assign ge        = (rem_r >= dsh_r);
  assign diff      = rem_r - dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= prod;
      dsh_r <= {1'b0, req.denom, {(DIV_STEPS - 1){1'b0}}};
      q_r   <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= diff;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[PCT_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

// File: rtl/core/fragment_reassembly_checker.sv
// ---------------------------------------------------------------------------
// fragment_reassembly_checker
// checks received file-transfer frame headers against the session state
// ---------------------------------------------------------------------------
// One header item is taken at a time. It is held in the item registers and
// checked in S_CHECK; an item that ends in a reject, an info frame or an end
// frame goes straight to S_DONE with its result registered, while an accepted
// data frame waits in S_DIV for the percent divider, which forms one quotient
// bit per cycle, before its progress is registered. The input is stalled
// while an item is in work and while the finished result cannot yet be
// loaded into the output register; a new item is taken while a result waits
// there.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fragment_reassembly_checker
  import frc_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX  = 1024,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [LEN_W-1:0]  in_frame_length,
  input  logic [LEN_W-1:0]  in_type_code,
  input  logic [WORD_W-1:0] in_announced_total,
  input  logic [WORD_W-1:0] in_seq_number,
  input  logic [SRC_W-1:0]  in_source_addr,
  input  logic              in_name_terminated,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic [2:0]        out_status,
  output logic [WL_W-1:0]   out_write_length,
  output logic [PCT_W-1:0]  out_progress,
  output logic              out_progress_changed,
  output logic              out_finished
);

  localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] PLD_MAX = LEN_W'(PAYLOAD_MAX);

  fsm_t state_r, state_nxt;

  logic [LEN_W-1:0]  cfg_type_r;

  logic              sess_open_r, sess_open_nxt;
  logic [WORD_W-1:0] exp_total_r, exp_total_nxt;
  logic [WORD_W-1:0] next_seq_r, next_seq_nxt;
  logic [WORD_W-1:0] bytes_r, bytes_nxt;
  logic [PCT_W-1:0]  last_pct_r, last_pct_nxt;
  logic [SRC_W-1:0]  lock_src_r, lock_src_nxt;

  cmd_t              it_cmd_r;
  logic [LEN_W-1:0]  it_flen_r;
  logic [LEN_W-1:0]  it_type_r;
  logic [WORD_W-1:0] it_total_r;
  logic [WORD_W-1:0] it_seq_r;
  logic [SRC_W-1:0]  it_src_r;
  logic              it_named_r;

  logic              res_acc_r, res_acc_nxt;
  status_t           res_stat_r, res_stat_nxt;
  logic [WL_W-1:0]   res_wl_r, res_wl_nxt;
  logic [PCT_W-1:0]  res_pct_r, res_pct_nxt;
  logic              res_chg_r, res_chg_nxt;
  logic              res_fin_r, res_fin_nxt;

  logic              out_valid_r;
  logic              out_acc_r;
  status_t           out_stat_r;
  logic [WL_W-1:0]   out_wl_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic              out_chg_r;
  logic              out_fin_r;

  logic              in_take;
  logic              out_free;
  logic              cfg_wr;

  logic [LEN_W-1:0]  plen_raw;
  logic [LEN_W-1:0]  plen;
  logic [WORD_W-1:0] remaining;
  logic              rem_short;
  logic [LEN_W-1:0]  wl;
  logic [WORD_W-1:0] bytes_add;
  logic              data_go;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_TYPE_CODE) begin
      prdata = {{(WORD_W - LEN_W){1'b0}}, cfg_type_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_type_r <= '0;
    end else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_TYPE_CODE)) begin
      cfg_type_r <= pwdata[LEN_W-1:0];
    end
  end

  // payload length and data frame arithmetic
  assign plen_raw  = it_flen_r - HDR_LEN;
  assign plen      = (plen_raw > PLD_MAX) ? PLD_MAX : plen_raw;
  assign remaining = exp_total_r - bytes_r;
  assign rem_short = remaining < {{(WORD_W - LEN_W){1'b0}}, plen};
  assign wl        = rem_short ? remaining[LEN_W-1:0] : plen;
  assign bytes_add = bytes_r + {{(WORD_W - LEN_W){1'b0}}, plen};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_take) state_nxt = S_CHECK;
      S_CHECK: state_nxt = data_go ? S_DIV : S_DONE;
      S_DIV:   if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    div_req.start = (state_r == S_CHECK) && data_go;
    div_req.numer = bytes_nxt;
    div_req.denom = exp_total_r;
  end

  // frame check and session update
  always_comb begin
    sess_open_nxt = sess_open_r;
    exp_total_nxt = exp_total_r;
    next_seq_nxt  = next_seq_r;
    bytes_nxt     = bytes_r;
    last_pct_nxt  = last_pct_r;
    lock_src_nxt  = lock_src_r;
    res_acc_nxt   = res_acc_r;
    res_stat_nxt  = res_stat_r;
    res_wl_nxt    = res_wl_r;
    res_pct_nxt   = res_pct_r;
    res_chg_nxt   = res_chg_r;
    res_fin_nxt   = res_fin_r;
    data_go       = 1'b0;

    if (state_r == S_CHECK) begin
      res_acc_nxt = 1'b0;
      res_wl_nxt  = '0;
      res_pct_nxt = '0;
      res_chg_nxt = 1'b0;
      res_fin_nxt = 1'b0;
      if (it_flen_r < HDR_LEN) begin
        res_stat_nxt = STAT_SHORT;
      end else if (it_type_r != cfg_type_r) begin
        res_stat_nxt = STAT_WRONG_TYPE;
      end else if ((it_cmd_r != CMD_INFO) && sess_open_r && (lock_src_r != it_src_r)) begin
        res_stat_nxt = STAT_FOREIGN;
      end else begin
        unique case (it_cmd_r)
          CMD_INFO: begin
            if ((it_seq_r != '0) || (plen == '0) || !it_named_r) begin
              res_stat_nxt = STAT_BAD_INFO;
            end else begin
              sess_open_nxt = 1'b1;
              exp_total_nxt = it_total_r;
              next_seq_nxt  = WORD_W'(1);
              bytes_nxt     = '0;
              last_pct_nxt  = '0;
              lock_src_nxt  = it_src_r;
              res_acc_nxt   = 1'b1;
              res_stat_nxt  = STAT_OK;
              res_chg_nxt   = 1'b1;
            end
          end
          CMD_DATA: begin
            if (!sess_open_r || (plen == '0)) begin
              res_stat_nxt = STAT_IDLE_EMPTY;
            end else if ((it_total_r != exp_total_r) || (it_seq_r != next_seq_r) ||
                         (bytes_r >= exp_total_r)) begin
              sess_open_nxt = 1'b0;
              exp_total_nxt = '0;
              next_seq_nxt  = '0;
              bytes_nxt     = '0;
              last_pct_nxt  = PCT_NONE;
              lock_src_nxt  = '0;
              res_stat_nxt  = STAT_ORDER;
            end else begin
              bytes_nxt    = rem_short ? exp_total_r : bytes_add;
              next_seq_nxt = next_seq_r + WORD_W'(1);
              res_acc_nxt  = 1'b1;
              res_stat_nxt = STAT_OK;
              res_wl_nxt   = wl[WL_W-1:0];
              data_go      = 1'b1;
            end
          end
          CMD_END: begin
            if (!sess_open_r) begin
              res_stat_nxt = STAT_IDLE_EMPTY;
            end else begin
              sess_open_nxt = 1'b0;
              exp_total_nxt = '0;
              next_seq_nxt  = '0;
              bytes_nxt     = '0;
              last_pct_nxt  = PCT_NONE;
              lock_src_nxt  = '0;
              if ((it_total_r != exp_total_r) || (it_seq_r != next_seq_r) ||
                  (bytes_r != exp_total_r)) begin
                res_stat_nxt = STAT_ORDER;
              end else begin
                res_acc_nxt  = 1'b1;
                res_stat_nxt = STAT_OK;
                res_pct_nxt  = PCT_FULL;
                res_chg_nxt  = (last_pct_r != PCT_FULL);
                res_fin_nxt  = 1'b1;
              end
            end
          end
          default: begin
            res_stat_nxt = STAT_UNKNOWN;
          end
        endcase
      end
    end else if ((state_r == S_DIV) && div_rsp.done) begin
      res_pct_nxt  = div_rsp.quotient;
      res_chg_nxt  = (div_rsp.quotient != last_pct_r);
      last_pct_nxt = div_rsp.quotient;
    end
  end

  frc_pctdiv u_pctdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sess_open_r <= 1'b0;
      exp_total_r <= '0;
      next_seq_r  <= '0;
      bytes_r     <= '0;
      last_pct_r  <= PCT_NONE;
      lock_src_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sess_open_r <= sess_open_nxt;
      exp_total_r <= exp_total_nxt;
      next_seq_r  <= next_seq_nxt;
      bytes_r     <= bytes_nxt;
      last_pct_r  <= last_pct_nxt;
      lock_src_r  <= lock_src_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      it_cmd_r   <= cmd_t'(in_cmd);
      it_flen_r  <= in_frame_length;
      it_type_r  <= in_type_code;
      it_total_r <= in_announced_total;
      it_seq_r   <= in_seq_number;
      it_src_r   <= in_source_addr;
      it_named_r <= in_name_terminated;
    end
    res_acc_r  <= res_acc_nxt;
    res_stat_r <= res_stat_nxt;
    res_wl_r   <= res_wl_nxt;
    res_pct_r  <= res_pct_nxt;
    res_chg_r  <= res_chg_nxt;
    res_fin_r  <= res_fin_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_acc_r  <= res_acc_r;
      out_stat_r <= res_stat_r;
      out_wl_r   <= res_wl_r;
      out_pct_r  <= res_pct_r;
      out_chg_r  <= res_chg_r;
      out_fin_r  <= res_fin_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_acc_r;
  assign out_status           = out_stat_r;
  assign out_write_length     = out_wl_r;
  assign out_progress         = out_pct_r;
  assign out_progress_changed = out_chg_r;
  assign out_finished         = out_fin_r;

  `FRC_ASSERT_IMP(a_bytes_bounded, clk, rst_n, sess_open_r, bytes_r <= exp_total_r,
                  "bytes past total")
  `FRC_ASSERT_IMP(a_idle_clean, clk, rst_n, !sess_open_r,
                  (bytes_r == '0) && (last_pct_r == PCT_NONE), "closed session not cleared")
  `FRC_ASSERT_IMP(a_pct_range, clk, rst_n, div_rsp.done, div_rsp.quotient <= PCT_FULL,
                  "percent above full")
  `FRC_ASSERT(a_fin_full, clk, rst_n,
              (out_valid_r && out_fin_r) |-> (out_acc_r && (out_pct_r == PCT_FULL)),
              "finish without full progress")

endmodule

`default_nettype wire

// File: test/fragment_reassembly_checker_test.sv
// ----------------------------------------------------------------------------
// fragment reassembly checker testbench
// Drives frame header items into the checker, predicts every result from a
// behavioral copy of the session logic, and compares each result field by
// field. The file type register is set to several values between phases, and
// the sender and the receiver idle at different rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fragment_reassembly_checker_test;
  import frc_pkg::*;

  localparam int unsigned PAYLOAD_MAX     = 1024;
  localparam int unsigned HEADER_BYTES    = 12;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned LIMIT_NS        = 5_000_000;

  typedef struct packed {
    cmd_t              cmd;
    logic [LEN_W-1:0]  frame_length;
    logic [LEN_W-1:0]  type_code;
    logic [WORD_W-1:0] announced_total;
    logic [WORD_W-1:0] seq_number;
    logic [SRC_W-1:0]  source_addr;
    logic              name_terminated;
  } frame_t;

  typedef struct packed {
    logic             accepted;
    status_t          status;
    logic [WL_W-1:0]  write_length;
    logic [PCT_W-1:0] progress;
    logic             progress_changed;
    logic             finished;
  } verdict_t;

  class session_tracker;
    logic [LEN_W-1:0]  type_code_cfg;
    logic              session_live;
    logic [WORD_W-1:0] total_bytes;
    logic [WORD_W-1:0] next_seq;
    logic [WORD_W-1:0] bytes_seen;
    logic [PCT_W-1:0]  last_pct;
    logic [SRC_W-1:0]  locked_src;
    verdict_t          expected_verdicts[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       finished_count;
    int unsigned       status_count[8];

    function new();
      type_code_cfg = '0;
      mismatches = 0;
      checked = 0;
      finished_count = 0;
      foreach (status_count[i]) status_count[i] = 0;
      drop_session();
    endfunction

    function void drop_session();
      session_live = 1'b0;
      total_bytes = '0;
      next_seq = '0;
      bytes_seen = '0;
      last_pct = PCT_NONE;
      locked_src = '0;
    endfunction

    function void note_frame(frame_t f);
      verdict_t v;
      logic [LEN_W:0] plen;
      logic [WORD_W-1:0] remaining;
      logic [WORD_W-1:0] wl;
      logic [63:0] pct;
      v = '0;
      v.status = STAT_OK;
      plen = '0;
      if (f.frame_length < HEADER_BYTES) begin
        v.status = STAT_SHORT;
      end else begin
        plen = (LEN_W + 1)'(f.frame_length - HEADER_BYTES);
        if (plen > PAYLOAD_MAX) plen = (LEN_W + 1)'(PAYLOAD_MAX);
        if (f.type_code != type_code_cfg) begin
          v.status = STAT_WRONG_TYPE;
        end else if (f.cmd != CMD_INFO && session_live && locked_src != f.source_addr) begin
          v.status = STAT_FOREIGN;
        end else begin
          case (f.cmd)
            CMD_INFO: begin
              if (f.seq_number != 0 || plen == 0 || !f.name_terminated) begin
                v.status = STAT_BAD_INFO;
              end else begin
                total_bytes = f.announced_total;
                next_seq = 32'd1;
                bytes_seen = '0;
                last_pct = '0;
                locked_src = f.source_addr;
                session_live = 1'b1;
                v.accepted = 1'b1;
                v.progress_changed = 1'b1;
              end
            end
            CMD_DATA: begin
              if (!session_live || plen == 0) begin
                v.status = STAT_IDLE_EMPTY;
              end else if (f.announced_total != total_bytes || f.seq_number != next_seq ||
                           bytes_seen >= total_bytes) begin
                drop_session();
                v.status = STAT_ORDER;
              end else begin
                remaining = total_bytes - bytes_seen;
                wl = (remaining < plen) ? remaining : WORD_W'(plen);
                bytes_seen = bytes_seen + wl;
                next_seq = next_seq + 32'd1;
                pct = (64'(bytes_seen) * 64'd100) / 64'(total_bytes);
                v.accepted = 1'b1;
                v.write_length = wl[WL_W-1:0];
                v.progress = pct[PCT_W-1:0];
                v.progress_changed = (pct[PCT_W-1:0] != last_pct);
                last_pct = pct[PCT_W-1:0];
              end
            end
            CMD_END: begin
              if (!session_live) begin
                v.status = STAT_IDLE_EMPTY;
              end else if (f.announced_total != total_bytes || f.seq_number != next_seq ||
                           bytes_seen != total_bytes) begin
                drop_session();
                v.status = STAT_ORDER;
              end else begin
                v.accepted = 1'b1;
                v.progress = PCT_FULL;
                v.progress_changed = (last_pct != PCT_FULL);
                v.finished = 1'b1;
                drop_session();
              end
            end
            default: v.status = STAT_UNKNOWN;
          endcase
        end
      end
      expected_verdicts.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no pending item: acc=%0b st=%0d wl=%0d pr=%0d ch=%0b fin=%0b",
                   $time, got.accepted, got.status, got.write_length, got.progress,
                   got.progress_changed, got.finished);
        return;
      end
      want = expected_verdicts.pop_front();
      checked++;
      status_count[want.status]++;
      if (want.finished) finished_count++;
      if (got.accepted !== want.accepted || got.status !== want.status ||
          got.write_length !== want.write_length || got.progress !== want.progress ||
          got.progress_changed !== want.progress_changed || got.finished !== want.finished) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch on result %0d", $time, checked);
          $display("  expected acc=%0b st=%0d wl=%0d pr=%0d ch=%0b fin=%0b",
                   want.accepted, want.status, want.write_length, want.progress,
                   want.progress_changed, want.finished);
          $display("  actual   acc=%0b st=%0d wl=%0d pr=%0d ch=%0b fin=%0b",
                   got.accepted, got.status, got.write_length, got.progress,
                   got.progress_changed, got.finished);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [WORD_W-1:0] pwdata = '0;
  logic [WORD_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_cmd = '0;
  logic [LEN_W-1:0]  in_frame_length = '0;
  logic [LEN_W-1:0]  in_type_code = '0;
  logic [WORD_W-1:0] in_announced_total = '0;
  logic [WORD_W-1:0] in_seq_number = '0;
  logic [SRC_W-1:0]  in_source_addr = '0;
  logic              in_name_terminated = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_accepted;
  logic [2:0]        out_status;
  logic [WL_W-1:0]   out_write_length;
  logic [PCT_W-1:0]  out_progress;
  logic              out_progress_changed;
  logic              out_finished;

  session_tracker    board = new();
  logic [LEN_W-1:0]  cur_type = '0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       items_sent = 0;
  int unsigned       config_writes = 0;

  fragment_reassembly_checker #(
    .PAYLOAD_MAX  (PAYLOAD_MAX),
    .HEADER_BYTES (HEADER_BYTES)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_frame_length      (in_frame_length),
    .in_type_code         (in_type_code),
    .in_announced_total   (in_announced_total),
    .in_seq_number        (in_seq_number),
    .in_source_addr       (in_source_addr),
    .in_name_terminated   (in_name_terminated),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_accepted         (out_accepted),
    .out_status           (out_status),
    .out_write_length     (out_write_length),
    .out_progress         (out_progress),
    .out_progress_changed (out_progress_changed),
    .out_finished         (out_finished)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_verdict({out_accepted, status_t'(out_status), out_write_length,
                           out_progress, out_progress_changed, out_finished});
  end

  function automatic frame_t make_frame(cmd_t cmd, int unsigned flen,
                                        logic [WORD_W-1:0] total, logic [WORD_W-1:0] seq,
                                        logic [SRC_W-1:0] src, logic named);
    frame_t f;
    f.cmd = cmd;
    f.frame_length = LEN_W'(flen);
    f.type_code = cur_type;
    f.announced_total = total;
    f.seq_number = seq;
    f.source_addr = src;
    f.name_terminated = named;
    return f;
  endfunction

  // occasionally break one field of an otherwise well-formed item
  function automatic frame_t maybe_damage(frame_t f);
    if ($urandom_range(99) >= 7) return f;
    case ($urandom_range(7))
      0: f.frame_length = LEN_W'($urandom_range(HEADER_BYTES - 1, 0));
      1: f.type_code = f.type_code ^ LEN_W'($urandom_range(65535, 1));
      2: f.source_addr = f.source_addr ^ (48'd1 << $urandom_range(SRC_W - 1));
      3: f.seq_number = f.seq_number + WORD_W'($urandom_range(3, 1));
      4: f.announced_total = f.announced_total ^ (32'd1 << $urandom_range(WORD_W - 1));
      5: f.cmd = CMD_OTHER;
      6: f.name_terminated = 1'b0;
      default: f.frame_length = LEN_W'(HEADER_BYTES);
    endcase
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= f.cmd;
    in_frame_length <= f.frame_length;
    in_type_code <= f.type_code;
    in_announced_total <= f.announced_total;
    in_seq_number <= f.seq_number;
    in_source_addr <= f.source_addr;
    in_name_terminated <= f.name_terminated;
    do @(posedge clk); while (in_stall);
    board.note_frame(f);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_type_code(logic [LEN_W-1:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(REG_TYPE_CODE));
    pwdata <= WORD_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LEN_W-1:0] !== value) begin
      board.mismatches++;
      if (board.mismatches <= MAX_REPORTS)
        $display("%0t: type code readback expected %h actual %h", $time, value, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    cur_type = value;
    board.type_code_cfg = value;
    config_writes++;
  endtask

  task automatic run_directed();
    frame_t f;
    logic [SRC_W-1:0] src_a;
    logic [SRC_W-1:0] src_b;
    src_a = '1;
    src_b = '0;
    send_frame(make_frame(CMD_DATA, 0, 0, 0, src_a, 0));
    send_frame(make_frame(CMD_INFO, HEADER_BYTES - 1, 100, 0, src_a, 1));
    f = make_frame(CMD_INFO, HEADER_BYTES, 100, 0, src_a, 1);
    f.type_code = ~cur_type;
    send_frame(f);
    send_frame(make_frame(CMD_OTHER, 100, 0, 0, src_b, 0));
    send_frame(make_frame(CMD_DATA, 100, 0, 0, src_b, 0));
    send_frame(make_frame(CMD_END, 100, 0, 0, src_b, 0));
    send_frame(make_frame(CMD_INFO, 100, 2000, 32'hffff_ffff, src_a, 1));
    send_frame(make_frame(CMD_INFO, HEADER_BYTES, 2000, 0, src_a, 1));
    send_frame(make_frame(CMD_INFO, 100, 2000, 0, src_a, 0));
    send_frame(make_frame(CMD_INFO, 65535, 2000, 0, src_a, 1));
    send_frame(make_frame(CMD_DATA, 100, 2000, 1, src_b, 1));
    send_frame(make_frame(CMD_OTHER, 100, 2000, 1, src_b, 1));
    send_frame(make_frame(CMD_OTHER, 100, 2000, 1, src_a, 1));
    send_frame(make_frame(CMD_DATA, HEADER_BYTES, 2000, 1, src_a, 1));
    send_frame(make_frame(CMD_DATA, 65535, 2000, 1, src_a, 1));
    send_frame(make_frame(CMD_DATA, HEADER_BYTES + 1500, 2000, 2, src_a, 1));
    send_frame(make_frame(CMD_DATA, 100, 2000, 3, src_a, 1));
    // zero-length file completes with its end frame alone
    send_frame(make_frame(CMD_INFO, 20, 0, 0, src_b, 1));
    send_frame(make_frame(CMD_END, HEADER_BYTES, 0, 1, src_b, 0));
    send_frame(make_frame(CMD_INFO, 20, 32'hffff_ffff, 0, src_a, 1));
    send_frame(make_frame(CMD_DATA, 112, 32'hffff_fffe, 1, src_a, 1));
    send_frame(make_frame(CMD_INFO, 20, 32'hffff_ffff, 0, src_a, 1));
    send_frame(make_frame(CMD_DATA, 112, 32'hffff_ffff, 1, src_a, 1));
    send_frame(make_frame(CMD_END, 112, 32'hffff_ffff, 2, src_a, 1));
    send_frame(make_frame(CMD_INFO, 20, 300, 0, src_a, 1));
    send_frame(make_frame(CMD_DATA, 412, 300, 1, src_a, 1));
    send_frame(make_frame(CMD_END, 50, 300, 2, src_a, 1));
  endtask

  task automatic run_session();
    logic [SRC_W-1:0] src;
    logic [WORD_W-1:0] total;
    logic [WORD_W-1:0] got;
    logic [WORD_W-1:0] seq;
    int unsigned sel;
    int unsigned flen;
    int unsigned plen;
    int unsigned frames;
    src = {16'($urandom), 32'($urandom)};
    sel = $urandom_range(99);
    if (sel < 60) total = $urandom_range(6000, 1);
    else if (sel < 85) total = $urandom_range(64, 0);
    else total = $urandom;
    send_frame(maybe_damage(make_frame(CMD_INFO,
      $urandom_range(HEADER_BYTES + PAYLOAD_MAX, HEADER_BYTES + 1), total, 0, src, 1)));
    got = '0;
    seq = 32'd1;
    frames = 0;
    while (got < total && frames < 10) begin
      sel = $urandom_range(99);
      if (sel < 85) flen = $urandom_range(HEADER_BYTES + PAYLOAD_MAX, HEADER_BYTES + 1);
      else if (sel < 95) flen = $urandom_range(65535, HEADER_BYTES + PAYLOAD_MAX);
      else flen = $urandom_range(HEADER_BYTES + 40, HEADER_BYTES + 1);
      send_frame(maybe_damage(make_frame(CMD_DATA, flen, total, seq, src,
                                         1'($urandom_range(1)))));
      plen = (flen - HEADER_BYTES > PAYLOAD_MAX) ? PAYLOAD_MAX : flen - HEADER_BYTES;
      got = (total - got < plen) ? total : got + plen;
      seq = seq + 32'd1;
      frames++;
    end
    // with a one-in-ten chance, hold the sender until every outstanding result is back
    if ($urandom_range(9) == 0) wait_drained();
    send_frame(maybe_damage(make_frame(CMD_END, $urandom_range(65535, HEADER_BYTES),
                                       total, seq, src, 1'($urandom_range(1)))));
  endtask

  task automatic send_noise();
    frame_t f;
    f.cmd = cmd_t'(2'($urandom_range(3)));
    f.frame_length = LEN_W'($urandom);
    f.type_code = $urandom_range(1) ? cur_type : LEN_W'($urandom);
    f.announced_total = $urandom;
    f.seq_number = $urandom_range(3) == 0 ? '0 : WORD_W'($urandom);
    f.source_addr = {16'($urandom), 32'($urandom)};
    f.name_terminated = 1'($urandom_range(1));
    send_frame(f);
  endtask

  task automatic run_phase(int unsigned sender_idle, int unsigned receiver_idle,
                           logic [LEN_W-1:0] type_value);
    int unsigned goal;
    write_type_code(type_value);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    goal = items_sent + ITEMS_PER_PHASE;
    while (items_sent < goal) begin
      if ($urandom_range(9) < 8) run_session();
      else repeat ($urandom_range(3, 1)) send_noise();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_type_code(16'ha5c3);
    run_directed();
    run_phase(38, 86, 16'hffff);
    run_phase(86, 38, LEN_W'($urandom));
    run_phase(0, 0, 16'h0000);
    wait_drained();
    $display("summary: %0d frame headers over %0d type settings, %0d results checked",
             items_sent, config_writes, board.checked);
    $display("summary: %0d files finished, %0d order resets, %0d foreign, %0d bad info",
             board.finished_count, board.status_count[STAT_ORDER],
             board.status_count[STAT_FOREIGN], board.status_count[STAT_BAD_INFO]);
    if (board.mismatches == 0 && board.expected_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
